FILE: src/lcsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsr_pkg
// Constants and shared types for the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
package lcsr_pkg;

  localparam logic [30:0] MOD1       = 31'd2147483563;
  localparam logic [30:0] MOD2       = 31'd2147483399;
  localparam logic [30:0] MODM1      = 31'd2147483562;
  localparam logic [15:0] MUL1       = 16'd40014;
  localparam logic [15:0] MUL2       = 16'd40692;
  // 2^31 minus each modulus
  localparam logic [7:0]  FOLD1      = 8'd85;
  localparam logic [7:0]  FOLD2      = 8'd249;
  localparam logic [30:0] SEED_RESET = 31'd123456789;
  localparam int          WARMUP_EXTRA = 8;
  localparam logic [23:0] FRAC_MAX   = 24'd16777214;
  localparam logic        FUNC_DRAW  = 1'b0;
  localparam logic        FUNC_SEED  = 1'b1;

  typedef enum logic {
    GEN_FIRST,
    GEN_SECOND
  } gen_sel_t;

  typedef struct packed {
    gen_sel_t    sel;
    logic [30:0] x;
  } mm_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_ISSUE,
    ST_SEED_WAIT,
    ST_SEED_TAKE,
    ST_DRAW0,
    ST_DRAW1,
    ST_DRAW2,
    ST_DRAW3
  } state_t;

endpackage
`default_nettype wire

FILE: src/lcsr_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsr_modmul
// Shared two-stage modular multiplier: x * a mod m for either generator.
// ----------------------------------------------------------------------------
module lcsr_modmul (
  input  wire logic               clk,
  input  wire lcsr_pkg::mm_req_t  req,
  output logic [30:0]             value
);

  logic [46:0]        prod;
  lcsr_pkg::gen_sel_t sel1;
  logic [15:0]        mult;
  logic [7:0]         fold;
  logic [30:0]        modulus;
  logic [31:0]        folded;

  always_comb begin
    mult = (req.sel == lcsr_pkg::GEN_SECOND) ? lcsr_pkg::MUL2 : lcsr_pkg::MUL1;
  end

  always_ff @(posedge clk) begin
    prod <= 47'(req.x) * 47'(mult);
    sel1 <= req.sel;
  end

  // fold the high part back: 2^31 == fold (mod m)
  always_comb begin
    fold    = (sel1 == lcsr_pkg::GEN_SECOND) ? lcsr_pkg::FOLD2 : lcsr_pkg::FOLD1;
    modulus = (sel1 == lcsr_pkg::GEN_SECOND) ? lcsr_pkg::MOD2 : lcsr_pkg::MOD1;
    folded  = 32'(prod[46:31]) * 32'(fold) + 32'(prod[30:0]);
  end

  always_ff @(posedge clk) begin
    if (folded >= 32'(modulus)) begin
      value <= 31'(folded - 32'(modulus));
    end else begin
      value <= folded[30:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/lcsr_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsr_table
// Shuffle table memory with per-entry fill bits and registered read.
// ----------------------------------------------------------------------------
module lcsr_table #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [30:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [30:0]        rd_data
);

  logic [30:0]      mem [DEPTH];
  logic [DEPTH-1:0] filled;
  logic [30:0]      mem_q;
  logic             filled_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled   <= '0;
      filled_q <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        filled_q <= filled[rd_addr];
      end
    end
  end

  assign rd_data = filled_q ? mem_q : '0;

endmodule
`default_nettype wire

FILE: src/lcsr_frac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsr_frac
// Scales a raw value to a 0.24 fraction of the first modulus, clamped below one.
// ----------------------------------------------------------------------------
module lcsr_frac (
  input  wire logic [30:0] raw,
  output logic [23:0]      frac
);

  logic [23:0] est;
  logic [31:0] rem;
  logic [24:0] fixed;

  // raw >> 7 is the quotient or one short of it
  always_comb begin
    est   = raw[30:7];
    rem   = {1'b0, raw[6:0], 24'd0} + 32'(est) * 32'(lcsr_pkg::FOLD1);
    fixed = 25'(est) + 25'(rem >= 32'(lcsr_pkg::MOD1));
    if (fixed > 25'(lcsr_pkg::FRAC_MAX)) begin
      frac = lcsr_pkg::FRAC_MAX;
    end else begin
      frac = fixed[23:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two combined multiplicative LCGs with a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// One request yields one result. A draw (func 0) takes two passes through
// the shared two-stage modular multiplier, the slot quotient and the table
// read before the result register is loaded. A seed (func 1) first runs a
// warm-up that fills the table, then the same draw; each warm-up step waits
// for the multiplier's result. req_stall is high from acceptance until the
// result is loaded; a waiting result is held in the output register while the
// next request is taken.
module combined_lcg_shuffle_rng #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        func,
  input  wire logic [30:0] seed_value,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [30:0]      raw_value,
  output logic [23:0]      fraction
);

  localparam int     AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int     QW = AW + 1;
  localparam int     CW = $clog2(TABLE_DEPTH + lcsr_pkg::WARMUP_EXTRA);
  localparam longint SlotDivL   = longint'(1) + longint'(lcsr_pkg::MODM1) / TABLE_DEPTH;
  localparam longint SlotRecipL = (longint'(1) <<< 31) / SlotDivL;
  localparam logic [30:0]   SLOT_DIV   = SlotDivL[30:0];
  localparam logic [QW-1:0] SLOT_RECIP = SlotRecipL[QW-1:0];

  lcsr_pkg::state_t  state;
  lcsr_pkg::state_t  state_next;
  lcsr_pkg::mm_req_t mm_req;
  logic [30:0]       mm_value;

  logic [30:0]    g1;
  logic [30:0]    g2;
  logic [30:0]    last;
  logic [CW-1:0]  cnt;
  logic [QW-1:0]  q_est;
  logic [AW-1:0]  slot;
  logic           pending;
  logic           out_free;

  logic [30:0]    seed_init;
  logic [30+QW:0] slot_prod;
  logic [30:0]    q_mul;
  logic [30:0]    slot_rem;
  logic [QW-1:0]  q_fix;
  logic [AW-1:0]  slot_calc;
  logic [30:0]    mix;
  logic [23:0]    frac_calc;

  logic           tbl_wr_en;
  logic [AW-1:0]  tbl_wr_addr;
  logic [30:0]    tbl_wr_data;
  logic           tbl_rd_en;
  logic [30:0]    tbl_rd_data;

  lcsr_modmul u_modmul (
    .clk   (clk),
    .req   (mm_req),
    .value (mm_value)
  );

  lcsr_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (slot),
    .rd_data (tbl_rd_data)
  );

  lcsr_frac u_frac (
    .raw  (last),
    .frac (frac_calc)
  );

  assign out_free  = !result_valid || !result_stall;
  assign seed_init = (seed_value == 31'd0) ? 31'd1 : seed_value;

  always_comb begin
    slot_prod = (31 + QW)'(last) * (31 + QW)'(SLOT_RECIP);
    q_mul     = 31'(q_est) * SLOT_DIV;
    slot_rem  = last - q_mul;
    q_fix     = q_est + QW'(slot_rem >= SLOT_DIV);
    if (q_fix > QW'(TABLE_DEPTH - 1)) begin
      slot_calc = AW'(TABLE_DEPTH - 1);
    end else begin
      slot_calc = q_fix[AW-1:0];
    end
    if (tbl_rd_data <= mm_value) begin
      mix = tbl_rd_data - mm_value + lcsr_pkg::MODM1;
    end else begin
      mix = tbl_rd_data - mm_value;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lcsr_pkg::ST_IDLE: begin
        if (req_valid && !pending) begin
          state_next = (func == lcsr_pkg::FUNC_SEED) ? lcsr_pkg::ST_SEED_ISSUE
                                                     : lcsr_pkg::ST_DRAW0;
        end
      end
      lcsr_pkg::ST_SEED_ISSUE: state_next = lcsr_pkg::ST_SEED_WAIT;
      lcsr_pkg::ST_SEED_WAIT:  state_next = lcsr_pkg::ST_SEED_TAKE;
      lcsr_pkg::ST_SEED_TAKE: begin
        state_next = (cnt == '0) ? lcsr_pkg::ST_DRAW0 : lcsr_pkg::ST_SEED_WAIT;
      end
      lcsr_pkg::ST_DRAW0: state_next = lcsr_pkg::ST_DRAW1;
      lcsr_pkg::ST_DRAW1: state_next = lcsr_pkg::ST_DRAW2;
      lcsr_pkg::ST_DRAW2: state_next = lcsr_pkg::ST_DRAW3;
      lcsr_pkg::ST_DRAW3: state_next = lcsr_pkg::ST_IDLE;
      default:            state_next = lcsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall   = (state != lcsr_pkg::ST_IDLE) || pending;
    mm_req.sel  = lcsr_pkg::GEN_FIRST;
    mm_req.x    = g1;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = slot;
    tbl_wr_data = g1;
    tbl_rd_en   = 1'b0;
    case (state)
      lcsr_pkg::ST_SEED_TAKE: begin
        mm_req.x    = mm_value;
        tbl_wr_en   = (cnt < CW'(TABLE_DEPTH));
        tbl_wr_addr = cnt[AW-1:0];
        tbl_wr_data = mm_value;
      end
      lcsr_pkg::ST_DRAW1: begin
        mm_req.sel = lcsr_pkg::GEN_SECOND;
        mm_req.x   = g2;
      end
      lcsr_pkg::ST_DRAW2: tbl_rd_en = 1'b1;
      lcsr_pkg::ST_DRAW3: tbl_wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lcsr_pkg::ST_IDLE;
      g1           <= 31'd1;
      g2           <= lcsr_pkg::SEED_RESET;
      last         <= '0;
      pending      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // hold the finished draw until the output register frees up
      if (pending && out_free) begin
        pending      <= 1'b0;
        result_valid <= 1'b1;
        raw_value    <= last;
        fraction     <= frac_calc;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        lcsr_pkg::ST_IDLE: begin
          if (req_valid && !pending && (func == lcsr_pkg::FUNC_SEED)) begin
            g1  <= seed_init;
            g2  <= seed_init;
            cnt <= CW'(TABLE_DEPTH + lcsr_pkg::WARMUP_EXTRA - 1);
          end
        end
        lcsr_pkg::ST_SEED_TAKE: begin
          g1  <= mm_value;
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            last <= mm_value;
          end
        end
        lcsr_pkg::ST_DRAW0: q_est <= slot_prod[30+QW:31];
        lcsr_pkg::ST_DRAW1: slot  <= slot_calc;
        lcsr_pkg::ST_DRAW2: g1    <= mm_value;
        lcsr_pkg::ST_DRAW3: begin
          g2      <= mm_value;
          last    <= mix;
          pending <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
